/* design/swqt_pkg.sv */
// Package for the semaphore wait-queue table: sizes, command and status codes,
// and the command/status structs between controller and datapath. No dependencies.
package swqt_pkg;

    localparam int MaxProcs = 16;
    localparam int IdxW     = $clog2(MaxProcs);
    localparam int CntW     = $clog2(MaxProcs + 1);
    localparam int KeyW     = 32;
    localparam int ProcW    = 4;

    typedef logic [IdxW-1:0] t_idx;

    localparam logic [1:0] KIND_BLOCK   = 2'd0;
    localparam logic [1:0] KIND_UNBLOCK = 2'd1;
    localparam logic [1:0] KIND_REMOVE  = 2'd2;
    localparam logic [1:0] KIND_PEEK    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request
        logic scan_clr;   // reset the scan counter
        logic scan_step;  // examine one slot or one link
        logic walk_init;  // start the queue walk at the slot head
        logic do_block;   // link the process into the found or free slot
        logic do_pop;     // pop the head of the found slot, or of the process's slot on a removal
        logic do_unlink;  // splice the process out after the walk pointer
        logic emit;       // present the result this cycle
        logic [1:0] st;
        logic pvalid;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic proc_bad;    // process number out of range
        logic proc_wait;   // process already waiting
        logic scan_done;   // scan counter has passed the last entry
        logic hit;         // a key match has been found in the scan
        logic have_free;   // a free slot was seen
        logic head_is_p;   // head of the process's slot is the process
        logic link_is_p;   // walk node links to the process
        logic walk_end;    // walk node is the tail
    } t_stat;

endpackage

/* design/swqt_datapath.sv */
// Datapath of the semaphore wait-queue table: request registers, slot and
// process stores, scan counter and walk pointer. Depends on swqt_pkg.
module swqt_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_kind,
    input  logic [31:0]            i_sem_address,
    input  logic [3:0]             i_process_number,
    input  swqt_pkg::t_cmd         i_cmd,
    output swqt_pkg::t_stat        o_stat,
    output logic [3:0]             o_result_process
);
    import swqt_pkg::*;

    logic [KeyW-1:0]  r_key;
    logic [1:0]       r_kind;
    logic [ProcW-1:0] r_proc;
    logic [KeyW-1:0]  r_slot_key [MaxProcs];
    t_idx             r_slot_head [MaxProcs];
    t_idx             r_slot_tail [MaxProcs];
    t_idx             r_link [MaxProcs];
    t_idx             r_pslot [MaxProcs];
    logic [MaxProcs-1:0] r_active, r_waiting;
    logic [CntW-1:0]  r_cnt;
    t_idx             r_slot;      // found slot
    logic             r_found;
    t_idx             r_free;
    logic             r_have_free;
    t_idx             r_q;         // walk pointer

    t_idx p_idx, c_idx, s_rm, blk_s, h;
    logic proc_bad;

    // The process index is the low bits; wider process numbers are out of range.
    assign proc_bad = ({{(32-ProcW){1'b0}}, r_proc} >= 32'(MaxProcs));
    assign p_idx    = t_idx'(r_proc);
    assign c_idx    = r_cnt[IdxW-1:0];
    assign s_rm     = r_pslot[p_idx];
    assign blk_s    = r_found ? r_slot : r_free;
    assign h        = r_slot_head[r_slot];

    always_comb begin
        o_stat.kind      = r_kind;
        o_stat.proc_bad  = proc_bad;
        o_stat.proc_wait = r_waiting[p_idx];
        o_stat.scan_done = (r_cnt == CntW'(MaxProcs));
        o_stat.hit       = r_found;
        o_stat.have_free = r_have_free;
        o_stat.head_is_p = (r_slot_head[s_rm] == p_idx);
        o_stat.link_is_p = (r_link[r_q] == p_idx);
        o_stat.walk_end  = (r_q == r_slot_tail[s_rm]);
    end

    // Result process: head for peek/pop, else the named process.
    always_comb begin
        o_result_process = '0;
        if (i_cmd.pvalid) begin
            if (r_kind == KIND_REMOVE) o_result_process = r_proc;
            else o_result_process = ProcW'(h);
        end
    end

    // Control bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_waiting <= '0;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            if (i_cmd.scan_clr) begin
                r_cnt <= '0;
                r_found <= 1'b0;
                r_have_free <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cnt <= r_cnt + 1'b1;
                if (!r_found && r_active[c_idx] && r_slot_key[c_idx] == r_key) begin
                    r_found <= 1'b1;
                end
                if (!r_have_free && !r_active[c_idx]) begin
                    r_have_free <= 1'b1;
                end
            end
            if (i_cmd.do_block) begin
                r_active[blk_s]  <= 1'b1;
                r_waiting[p_idx] <= 1'b1;
            end
            if (i_cmd.do_pop) begin
                if (r_kind == KIND_REMOVE) begin
                    r_waiting[p_idx] <= 1'b0;
                    if (r_slot_tail[s_rm] == p_idx) r_active[s_rm] <= 1'b0;
                end else begin
                    r_waiting[h] <= 1'b0;
                    if (h == r_slot_tail[r_slot]) r_active[r_slot] <= 1'b0;
                end
            end
            if (i_cmd.do_unlink) r_waiting[p_idx] <= 1'b0;
        end
    end

    // Payload registers and stores.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_key  <= i_sem_address;
            r_proc <= i_process_number;
        end
        if (i_cmd.scan_step) begin
            if (!r_found && r_active[c_idx] && r_slot_key[c_idx] == r_key) r_slot <= c_idx;
            if (!r_have_free && !r_active[c_idx]) r_free <= c_idx;
        end
        if (i_cmd.walk_init) r_q <= r_slot_head[s_rm];
        else if (i_cmd.scan_step) r_q <= r_link[r_q];
        if (i_cmd.do_block) begin
            if (!r_found) begin
                r_slot_key[blk_s]  <= r_key;
                r_slot_head[blk_s] <= p_idx;
            end else begin
                r_link[r_slot_tail[blk_s]] <= p_idx;
            end
            r_slot_tail[blk_s] <= p_idx;
            r_pslot[p_idx] <= blk_s;
        end
        if (i_cmd.do_pop) begin
            if (r_kind == KIND_REMOVE) r_slot_head[s_rm] <= r_link[p_idx];
            else r_slot_head[r_slot] <= r_link[h];
        end
        if (i_cmd.do_unlink) begin
            if (r_slot_tail[s_rm] == p_idx) begin
                r_slot_tail[s_rm] <= r_q;
                r_link[r_q] <= r_q;
            end else begin
                r_link[r_q] <= r_link[p_idx];
            end
        end
    end

endmodule

/* design/swqt_ctrl.sv */
// Controller state machine of the semaphore wait-queue table.
// Depends on swqt_pkg.
module swqt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  swqt_pkg::t_stat i_stat,
    output swqt_pkg::t_cmd  o_cmd
);
    import swqt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.kind == KIND_REMOVE) begin
                    if (i_stat.proc_bad || !i_stat.proc_wait) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.st = ST_NOTFOUND;
                        n_state = S_IDLE;
                    end else if (i_stat.head_is_p) begin
                        o_cmd.do_pop = 1'b1;
                        o_cmd.emit = 1'b1;
                        o_cmd.pvalid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.walk_init = 1'b1;
                        n_state = S_WALK;
                    end
                end else if (i_stat.kind == KIND_BLOCK &&
                             (i_stat.proc_bad || i_stat.proc_wait)) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.st = ST_NOTFOUND;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.scan_done) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
                if (i_stat.kind == KIND_BLOCK) begin
                    if (!i_stat.hit && !i_stat.have_free) begin
                        o_cmd.st = ST_FULL;
                    end else begin
                        o_cmd.do_block = 1'b1;
                    end
                end else if (!i_stat.hit) begin
                    o_cmd.st = ST_NOTFOUND;
                end else begin
                    o_cmd.pvalid = 1'b1;
                    o_cmd.do_pop = (i_stat.kind == KIND_UNBLOCK);
                end
            end
            S_WALK: begin
                // One link per cycle; the process waits in this queue.
                if (i_stat.link_is_p) begin
                    o_cmd.do_unlink = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.pvalid = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.walk_end) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.st = ST_NOTFOUND;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* design/semaphore_wait_queue_table_core.sv */
// Semaphore wait-queue table: one request at a time on a start/busy handshake,
// one result a request, shown for a single cycle under o_done; the receiver
// cannot stall it. The result comes in the check state on an early error or
// a removal at the queue head, after a walk of the queue, one link a cycle,
// for any other named removal, and after a scan of all 16 slot keys, one a
// cycle, for block, unblock and peek. Busy falls in the cycle after the
// result, so the next request can be taken then at the earliest. No clearing
// pass after reset.
// Top level; depends on swqt_pkg, swqt_ctrl and swqt_datapath.
module semaphore_wait_queue_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_sem_address,
    input  logic [3:0]  i_process_number,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_process_valid,
    output logic [3:0]  o_result_process
);
    import swqt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    swqt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    swqt_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_kind           (i_kind),
        .i_sem_address    (i_sem_address),
        .i_process_number (i_process_number),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_result_process (o_result_process)
    );

    // Result strobe and fields.
    assign o_done          = cmd.emit;
    assign o_status        = cmd.st;
    assign o_process_valid = cmd.pvalid;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench for semaphore_wait_queue_table_core: a queue-fed driver, a result monitor
// and a behavioral semaphore table that predicts each result. Depends on swqt_pkg.
module tb;
    import swqt_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [3:0]  proc;
    } t_request;

    typedef struct packed {
        logic [1:0] status;
        logic       pvalid;
        logic [3:0] rproc;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [31:0] i_sem_address;
    logic [3:0]  i_process_number;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_process_valid;
    logic [3:0]  o_result_process;

    semaphore_wait_queue_table_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_sem_address   (i_sem_address),
        .i_process_number(i_process_number),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_process_valid (o_process_valid),
        .o_result_process(o_result_process)
    );

    // Shadow copy of the semaphore table.
    logic [31:0] sem_key    [MaxProcs];
    logic        sem_active [MaxProcs];
    logic [3:0]  sem_head   [MaxProcs];
    logic [3:0]  sem_tail   [MaxProcs];
    logic [3:0]  proc_next  [MaxProcs];
    logic        proc_waits [MaxProcs];
    logic [3:0]  proc_sem   [MaxProcs];

    t_request pending_requests[$];
    t_answer  expected_answers[$];
    int       errors;
    int       cycles;
    int       send_idle_pct;
    bit       hold_sender;
    bit       stimulus_done;
    int       done_count;
    int       full_count;

    function automatic int find_sem(logic [31:0] key);
        for (int i = 0; i < MaxProcs; i++)
            if (sem_active[i] && sem_key[i] == key) return i;
        return -1;
    endfunction

    function automatic logic [3:0] pop_sem(int s);
        logic [3:0] h;
        h = sem_head[s];
        proc_waits[h] = 1'b0;
        if (h == sem_tail[s]) sem_active[s] = 1'b0;
        else sem_head[s] = proc_next[h];
        return h;
    endfunction

    // Apply one request to the shadow table and return the answer it gives.
    function automatic t_answer predict_answer(t_request r);
        t_answer a;
        int s;
        int q;
        bit found;
        a = '{status: ST_OK, pvalid: 1'b0, rproc: 4'd0};
        case (r.kind)
            KIND_BLOCK: begin
                if (proc_waits[r.proc]) begin
                    a.status = ST_NOTFOUND;
                    return a;
                end
                s = find_sem(r.key);
                if (s < 0) begin
                    for (int i = 0; i < MaxProcs; i++)
                        if (!sem_active[i]) begin
                            s = i;
                            break;
                        end
                    if (s < 0) begin
                        a.status = ST_FULL;
                        return a;
                    end
                    sem_active[s] = 1'b1;
                    sem_key[s] = r.key;
                    sem_head[s] = r.proc;
                end else begin
                    proc_next[sem_tail[s]] = r.proc;
                end
                sem_tail[s] = r.proc;
                proc_next[r.proc] = r.proc;
                proc_waits[r.proc] = 1'b1;
                proc_sem[r.proc] = s[3:0];
            end
            KIND_UNBLOCK, KIND_PEEK: begin
                s = find_sem(r.key);
                if (s < 0) begin
                    a.status = ST_NOTFOUND;
                    return a;
                end
                a.pvalid = 1'b1;
                a.rproc = (r.kind == KIND_PEEK) ? sem_head[s] : pop_sem(s);
            end
            default: begin
                if (!proc_waits[r.proc]) begin
                    a.status = ST_NOTFOUND;
                    return a;
                end
                s = proc_sem[r.proc];
                if (sem_head[s] == r.proc) begin
                    void'(pop_sem(s));
                end else begin
                    q = sem_head[s];
                    found = 1'b0;
                    for (int i = 0; i < MaxProcs; i++) begin
                        if (proc_next[q] == r.proc) begin
                            found = 1'b1;
                            break;
                        end
                        if (q == sem_tail[s]) break;
                        q = proc_next[q];
                    end
                    if (!found) begin
                        a.status = ST_NOTFOUND;
                        return a;
                    end
                    if (sem_tail[s] == r.proc) begin
                        sem_tail[s] = q[3:0];
                        proc_next[q] = q[3:0];
                    end else begin
                        proc_next[q] = proc_next[r.proc];
                    end
                    proc_waits[r.proc] = 1'b0;
                end
                a.pvalid = 1'b1;
                a.rproc = r.proc;
            end
        endcase
        return a;
    endfunction

    function automatic void push_request(logic [1:0] kind, logic [31:0] key,
                                         logic [3:0] proc);
        pending_requests.push_back('{kind: kind, key: key, proc: proc});
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Driver: presents requests from the queue, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // Request not yet taken; hold it.
        end else begin
            if (start) expected_answers.push_back(predict_answer(
                '{kind: i_kind, key: i_sem_address, proc: i_process_number}));
            if (pending_requests.size() > 0 && !hold_sender &&
                $urandom_range(99, 0) >= send_idle_pct) begin
                t_request r;
                r = pending_requests.pop_front();
                start <= 1'b1;
                i_kind <= r.kind;
                i_sem_address <= r.key;
                i_process_number <= r.proc;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compares each result with the oldest expectation.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            t_answer e;
            done_count <= done_count + 1;
            if (expected_answers.size() == 0) begin
                $error("result with no request outstanding");
                errors <= errors + 1;
            end else begin
                e = expected_answers.pop_front();
                if (e.status == ST_FULL) full_count <= full_count + 1;
                if (o_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_status);
                    errors <= errors + 1;
                end
                if (o_process_valid !== e.pvalid) begin
                    $error("process_valid: expected %0d, actual %0d", e.pvalid,
                           o_process_valid);
                    errors <= errors + 1;
                end
                if (o_result_process !== e.rproc) begin
                    $error("result_process: expected %0d, actual %0d", e.rproc,
                           o_result_process);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_key(int pool);
        case ($urandom_range(9, 0))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return 32'h8000_0000 ^ ($urandom_range(pool - 1, 0) * 32'h0101_0101);
        endcase
    endfunction

    function automatic void add_random_phase(int count);
        int pool;
        logic [1:0] k;
        pool = $urandom_range(20, 2);
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0) pool = $urandom_range(20, 2);
            // Blocks dominate so queues grow deep; then unblock and remove drain them.
            case ($urandom_range(9, 0))
                0, 1, 2, 3: k = KIND_BLOCK;
                4, 5:       k = KIND_UNBLOCK;
                6, 7:       k = KIND_REMOVE;
                default:    k = KIND_PEEK;
            endcase
            push_request(k, pick_key(pool), 4'($urandom_range(15, 0)));
        end
    endfunction

    task automatic drain_queue;
        while (pending_requests.size() > 0 || start || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    // Stimulus.
    initial begin
        errors = 0;
        cycles = 0;
        done_count = 0;
        full_count = 0;
        send_idle_pct = 0;
        hold_sender = 1'b0;
        stimulus_done = 1'b0;
        start = 1'b0;
        i_kind = KIND_PEEK;
        i_sem_address = '0;
        i_process_number = '0;
        for (int i = 0; i < MaxProcs; i++) begin
            sem_active[i] = 1'b0;
            proc_waits[i] = 1'b0;
            sem_key[i] = '0;
            sem_head[i] = '0;
            sem_tail[i] = '0;
            proc_next[i] = '0;
            proc_sem[i] = '0;
        end
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: absent keys, extreme keys, idle removal, double block.
        push_request(KIND_PEEK, 32'h0000_0000, 4'd0);
        push_request(KIND_UNBLOCK, 32'hFFFF_FFFF, 4'd0);
        push_request(KIND_REMOVE, 32'd0, 4'd15);
        push_request(KIND_BLOCK, 32'h0000_0000, 4'd0);
        push_request(KIND_BLOCK, 32'hFFFF_FFFF, 4'd15);
        push_request(KIND_BLOCK, 32'h0000_0000, 4'd0);
        push_request(KIND_BLOCK, 32'h0000_0000, 4'd5);
        push_request(KIND_BLOCK, 32'h0000_0000, 4'd9);
        push_request(KIND_PEEK, 32'h0000_0000, 4'd0);
        push_request(KIND_REMOVE, 32'd0, 4'd5);
        push_request(KIND_REMOVE, 32'd0, 4'd9);
        push_request(KIND_UNBLOCK, 32'h0000_0000, 4'd0);
        push_request(KIND_PEEK, 32'h0000_0000, 4'd0);
        push_request(KIND_REMOVE, 32'd0, 4'd15);
        push_request(KIND_PEEK, 32'hFFFF_FFFF, 4'd0);
        // Fill the table with one process per key, then try one key more.
        for (int p = 0; p < MaxProcs; p++)
            push_request(KIND_BLOCK, 32'h1000_0000 + p, 4'(p));
        push_request(KIND_REMOVE, 32'd0, 4'd3);
        push_request(KIND_BLOCK, 32'h2000_0000, 4'd3);
        push_request(KIND_BLOCK, 32'h3000_0000, 4'd3);
        for (int p = 0; p < MaxProcs; p++)
            push_request(KIND_UNBLOCK, 32'h1000_0000 + p, 4'd0);
        push_request(KIND_UNBLOCK, 32'h2000_0000, 4'd0);
        drain_queue();

        // Random phases; each ends with the sender holding off until all results are in.
        send_idle_pct = 13;
        add_random_phase(700);
        drain_queue();
        send_idle_pct = 82;
        add_random_phase(600);
        // Midway through, the sender stops until every outstanding result is back.
        while (pending_requests.size() > 300)
            @(posedge i_clk);
        hold_sender = 1'b1;
        while (start || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        hold_sender = 1'b0;
        drain_queue();
        send_idle_pct = 0;
        add_random_phase(700);
        drain_queue();

        $display("Ran %0d requests over mixed key pools, %0d of them hitting a full table.",
                 done_count, full_count);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/swqt_pkg.sv
design/swqt_datapath.sv
design/swqt_ctrl.sv
design/semaphore_wait_queue_table_core.sv
sim/tb.sv
